/* sv/pfa_pkg.sv */
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int unsigned RUN_W = 11;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_INC   = 3'd3,
    OP_DEC   = 3'd4,
    OP_READ  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_TOTAL    = 2'd0,
    CFG_RESERVED = 2'd1,
    CFG_TABLE    = 2'd2
  } cfg_index_t;

  // decoded command kinds handed from front to back
  typedef enum logic [2:0] {
    K_INIT,
    K_ALLOC,
    K_ALLOC_ZERO,
    K_FREE,
    K_INC,
    K_DEC,
    K_READ,
    K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_SCAN,
    B_AWRITE,
    B_RWAIT,
    B_FWRITE,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] page_count;
    logic [9:0]  page_index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  start_page;
    logic [15:0] ref_value;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] count;
    logic [9:0]  page;
  } cmd_t;

endpackage

/* sv/pfa_front.sv */
`timescale 1ns / 1ps
module pfa_front import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  // opcode decode
  always_comb begin
    decoded.count = in_data.page_count;
    decoded.page  = in_data.page_index;
    case (in_data.opcode)
      OP_INIT:  decoded.kind = K_INIT;
      OP_ALLOC: decoded.kind = (in_data.page_count == 11'd0) ? K_ALLOC_ZERO : K_ALLOC;
      OP_FREE:  decoded.kind = K_FREE;
      OP_INC:   decoded.kind = K_INC;
      OP_DEC:   decoded.kind = K_DEC;
      OP_READ:  decoded.kind = K_READ;
      default:  decoded.kind = K_BAD;
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/pfa_back.sv */
`timescale 1ns / 1ps
module pfa_back import pfa_pkg::*; #(
  parameter int unsigned MAX_PAGES = 1024,
  parameter int unsigned REF_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  input  logic       cfg_valid,
  input  cfg_index_t cfg_index,
  input  logic [10:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int unsigned AW = $clog2(MAX_PAGES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = 1 + RUN_W + REF_BITS;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [EW-1:0] mem [MAX_PAGES];
  logic [EW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [EW-1:0] wdata;

  logic [10:0] total_pages;
  logic [10:0] low_reserved_pages;
  logic [10:0] table_pages;

  back_state_t state, state_next;
  cmd_t        cur, cur_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] chk_idx, chk_idx_next;
  logic          chk, chk_next;
  logic [CW-1:0] base, base_next;
  logic [11:0]   k, k_next;
  logic [10:0]   cnt, cnt_next;
  logic [CW-1:0] active, active_next;
  logic [CW-1:0] lim_t, lim_t_next;
  logic [CW-1:0] lim_r, lim_r_next;
  out_item_t     res, res_next;

  logic                rd_used;
  logic [RUN_W-1:0]    rd_run;
  logic [REF_BITS-1:0] rd_ref;
  logic [REF_BITS-1:0] new_ref;
  logic [31:0] i32, t32, r32, tp32, cap32, pos32;

  assign rd_used = rdata[EW-1];
  assign rd_run  = rdata[REF_BITS +: RUN_W];
  assign rd_ref  = rdata[REF_BITS-1:0];

  // descriptor memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages        <= 11'd1024;
      low_reserved_pages <= 11'd0;
      table_pages        <= 11'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOTAL:    total_pages        <= cfg_data;
        CFG_RESERVED: low_reserved_pages <= cfg_data;
        CFG_TABLE:    table_pages        <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign i32  = 32'(idx);
  assign t32  = 32'(lim_t);
  assign r32  = 32'(lim_r);
  assign tp32 = 32'(table_pages);

  // sequencer: next state and memory control
  always_comb begin
    state_next   = state;
    cur_next     = cur;
    idx_next     = idx;
    chk_idx_next = chk_idx;
    chk_next     = 1'b0;
    base_next    = base;
    k_next       = k;
    cnt_next     = cnt;
    active_next  = active;
    lim_t_next   = lim_t;
    lim_r_next   = lim_r;
    res_next     = res;
    cmd_ready    = 1'b0;
    we           = 1'b0;
    waddr        = idx[AW-1:0];
    wdata        = '0;
    raddr        = AW'(cmd.page);
    new_ref      = rd_ref;
    cap32        = '0;
    pos32        = '0;

    case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_next = cmd;
          case (cmd.kind)
            K_INIT: begin
              idx_next = '0;
              cap32 = (32'(total_pages) < MAX_PAGES) ? 32'(total_pages) : MAX_PAGES;
              lim_t_next = CW'(cap32);
              lim_r_next = CW'((32'(low_reserved_pages) < cap32) ?
                               32'(low_reserved_pages) : cap32);
              state_next = B_INIT;
            end
            K_ALLOC: begin
              idx_next   = '0;
              state_next = B_SCAN;
            end
            K_ALLOC_ZERO: begin
              res_next   = '{status: ST_BAD, start_page: '0, ref_value: '0};
              state_next = B_DONE;
            end
            K_BAD: begin
              res_next   = '{status: ST_BAD, start_page: cmd.page, ref_value: '0};
              state_next = B_DONE;
            end
            default: begin
              if (32'(cmd.page) >= 32'(active)) begin
                res_next   = '{status: ST_BAD, start_page: cmd.page, ref_value: '0};
                state_next = B_DONE;
              end else begin
                state_next = B_RWAIT;
              end
            end
          endcase
        end
      end

      // table build, one descriptor per cycle
      B_INIT: begin
        we = 1'b1;
        if (i32 >= t32) begin
          wdata = '0;
          wdata[EW-1] = 1'b1;
        end else if (i32 < r32) begin
          wdata = {1'b1, RUN_W'(r32 - i32), REF_BITS'(1)};
        end else if ((i32 - r32) < tp32) begin
          wdata = {1'b1, RUN_W'(tp32 - (i32 - r32)), REF_BITS'(1)};
        end else begin
          wdata = {1'b0, RUN_W'(t32 - i32), REF_BITS'(0)};
        end
        idx_next = idx + CW'(1);
        if (i32 == MAX_PAGES - 1) begin
          active_next = lim_t;
          res_next    = '{status: ST_OK, start_page: '0, ref_value: '0};
          state_next  = B_DONE;
        end
      end

      // first-fit scan, reads pipelined one page a cycle
      B_SCAN: begin
        raddr = idx[AW-1:0];
        if (chk && !rd_used && (rd_run >= cur.count)) begin
          base_next  = chk_idx;
          k_next     = '0;
          state_next = B_AWRITE;
        end else if (!chk && (idx >= active)) begin
          res_next   = '{status: ST_NOSPACE, start_page: '0, ref_value: '0};
          state_next = B_DONE;
        end else if (idx < active) begin
          chk_next     = 1'b1;
          chk_idx_next = idx;
          idx_next     = idx + CW'(1);
        end
      end

      B_AWRITE: begin
        pos32 = 32'(base) + 32'(k);
        waddr = AW'(pos32);
        if ((32'(k) < 32'(cur.count)) && (pos32 < 32'(active))) begin
          we     = 1'b1;
          wdata  = {1'b1, RUN_W'(32'(cur.count) - 32'(k)), REF_BITS'(1)};
          k_next = k + 12'd1;
        end else begin
          res_next   = '{status: ST_OK, start_page: 10'(base), ref_value: 16'd1};
          state_next = B_DONE;
        end
      end

      // descriptor of the addressed page now in rdata
      B_RWAIT: begin
        waddr = AW'(cur.page);
        case (cur.kind)
          K_FREE: begin
            cnt_next   = rd_run;
            k_next     = '0;
            state_next = B_FWRITE;
          end
          K_INC: begin
            if (rd_ref != REF_MAX) new_ref = rd_ref + REF_BITS'(1);
            we = 1'b1;
          end
          K_DEC: begin
            if (rd_ref != '0) new_ref = rd_ref - REF_BITS'(1);
            we = 1'b1;
          end
          default: ;
        endcase
        wdata = {rd_used, rd_run, new_ref};
        if (cur.kind != K_FREE) begin
          res_next   = '{status: ST_OK, start_page: cur.page, ref_value: 16'(new_ref)};
          state_next = B_DONE;
        end
      end

      B_FWRITE: begin
        pos32 = 32'(cur.page) + 32'(k);
        waddr = AW'(pos32);
        if ((32'(k) < 32'(cnt)) && (pos32 < 32'(active))) begin
          we     = 1'b1;
          wdata  = {1'b0, RUN_W'(32'(cnt) - 32'(k)), REF_BITS'(0)};
          k_next = k + 12'd1;
        end else begin
          res_next   = '{status: ST_OK, start_page: cur.page, ref_value: '0};
          state_next = B_DONE;
        end
      end

      B_DONE: begin
        if (!out_valid || out_ready) state_next = B_IDLE;
      end

      default: state_next = B_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    idx     <= idx_next;
    chk_idx <= chk_idx_next;
    base    <= base_next;
    k       <= k_next;
    cnt     <= cnt_next;
    lim_t   <= lim_t_next;
    lim_r   <= lim_r_next;
    res     <= res_next;
    if (rst) begin
      state  <= B_IDLE;
      chk    <= 1'b0;
      active <= '0;
    end else begin
      state  <= state_next;
      chk    <= chk_next;
      active <= active_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == B_DONE && (!out_valid || out_ready)) out_data <= res;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sv/page_frame_allocator_unit.sv */
`timescale 1ns / 1ps
// channel | signals                          | direction
// in      | in_valid, in_ready, in_data      | item in: opcode, page_count, page_index
// out     | out_valid, out_ready, out_data   | item out: status, start_page, ref_value
// cfg     | cfg_valid, cfg_ready, cfg_index, | register write, always ready
//         | cfg_data                         |
// init writes all MAX_PAGES descriptors, one descriptor written per cycle.
// alloc does one memory read per page in the scan, then one write per
// granted page; no space scans all active pages. free does one write
// per freed page; reference ops read a descriptor and inc/dec write it back.
// one item is worked on at a time; a two-item queue keeps input open while
// the back end or the output stalls. after reset no page is managed until an
// init item has run.
module page_frame_allocator_unit import pfa_pkg::*; #(
  parameter int unsigned MAX_PAGES = 1024,
  parameter int unsigned REF_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [10:0] cfg_data
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  pfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pfa_back #(
    .MAX_PAGES (MAX_PAGES),
    .REF_BITS  (REF_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import pfa_pkg::*;

  localparam int unsigned PAGES   = 1024;
  localparam int unsigned CNT_MAX = 65535;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_TOTAL;
  logic [10:0] cfg_data = '0;

  page_frame_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predicted descriptor table and settings
  logic        used_mark [PAGES];
  logic [10:0] run_len [PAGES];
  logic [15:0] ref_cnt [PAGES];
  int unsigned managed_pages;
  logic [10:0] total_reg, reserved_reg, table_reg;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  bit        failed;
  bit        quiet_phase;
  int        in_gap, out_gap;

  function automatic out_item_t pack_result(status_t s, logic [9:0] p, logic [15:0] r);
    out_item_t o;
    o.status = s;
    o.start_page = p;
    o.ref_value = r;
    return o;
  endfunction

  function automatic void rebuild_table();
    int unsigned t, r;
    t = (total_reg < PAGES) ? total_reg : PAGES;
    r = (reserved_reg < t) ? reserved_reg : t;
    for (int unsigned i = 0; i < PAGES; i++) begin
      if (i >= t) begin
        used_mark[i] = 1; run_len[i] = 0; ref_cnt[i] = 0;
      end else if (i < r) begin
        used_mark[i] = 1; run_len[i] = 11'(r - i); ref_cnt[i] = 1;
      end else if (i - r < table_reg) begin
        used_mark[i] = 1; run_len[i] = 11'(table_reg - (i - r)); ref_cnt[i] = 1;
      end else begin
        used_mark[i] = 0; run_len[i] = 11'(t - i); ref_cnt[i] = 0;
      end
    end
    managed_pages = t;
  endfunction

  // allocator behaviour for one item
  function automatic out_item_t allocator_result(in_item_t it);
    int unsigned n, p, cnt;
    n = it.page_count;
    p = it.page_index;
    case (it.opcode)
      OP_INIT: begin
        rebuild_table();
        return pack_result(ST_OK, 0, 0);
      end
      OP_ALLOC: begin
        if (n == 0) return pack_result(ST_BAD, 0, 0);
        for (int unsigned i = 0; i < managed_pages; i++) begin
          if (!used_mark[i] && run_len[i] >= n) begin
            for (int unsigned k = 0; k < n && i + k < managed_pages; k++) begin
              used_mark[i+k] = 1; run_len[i+k] = 11'(n - k); ref_cnt[i+k] = 1;
            end
            return pack_result(ST_OK, 10'(i), 1);
          end
        end
        return pack_result(ST_NOSPACE, 0, 0);
      end
      default: ;
    endcase
    if (it.opcode > OP_READ || p >= managed_pages) return pack_result(ST_BAD, 10'(p), 0);
    case (it.opcode)
      OP_FREE: begin
        cnt = run_len[p];
        for (int unsigned k = 0; k < cnt && p + k < managed_pages; k++) begin
          used_mark[p+k] = 0; run_len[p+k] = 11'(cnt - k); ref_cnt[p+k] = 0;
        end
        return pack_result(ST_OK, 10'(p), 0);
      end
      OP_INC: if (ref_cnt[p] < CNT_MAX) ref_cnt[p]++;
      OP_DEC: if (ref_cnt[p] > 0) ref_cnt[p]--;
      default: ;
    endcase
    return pack_result(ST_OK, 10'(p), ref_cnt[p]);
  endfunction

  // driver: presents pending items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(allocator_result(in_data));
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks results and stalls the output at random
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_data);
          failed = 1;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            failed = 1;
          end
          if (out_data.start_page !== e.start_page) begin
            $error("start_page expected %0d actual %0d", e.start_page, out_data.start_page);
            failed = 1;
          end
          if (out_data.ref_value !== e.ref_value) begin
            $error("ref_value expected %0d actual %0d", e.ref_value, out_data.ref_value);
            failed = 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 15);
      end
    end
  end

  function automatic in_item_t make_item(opcode_t op, int unsigned n, int unsigned p);
    in_item_t it;
    it.opcode = op;
    it.page_count = 11'(n);
    it.page_index = 10'(p);
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [10:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOTAL:    total_reg = val;
      CFG_RESERVED: reserved_reg = val;
      default:      table_reg = val;
    endcase
  endtask

  // random traffic tuned to the managed size
  task automatic queue_random(int unsigned count, int unsigned span);
    int unsigned r;
    for (int unsigned j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        pending_items.push_back(make_item(OP_ALLOC, ($urandom_range(0, 9) == 0) ?
          $urandom_range(0, 2047) : $urandom_range(1, 8), $urandom));
      else if (r < 55)
        pending_items.push_back(make_item(OP_FREE, $urandom,
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span)));
      else if (r < 92)
        pending_items.push_back(make_item(opcode_t'($urandom_range(3, 5)), $urandom,
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span)));
      else if (r < 97)
        pending_items.push_back(make_item(opcode_t'($urandom_range(6, 7)), $urandom, $urandom));
      else
        pending_items.push_back(make_item(OP_INIT, $urandom, $urandom));
    end
  endtask

  initial begin
    total_reg = 1024; reserved_reg = 0; table_reg = 0;
    managed_pages = 0;
    foreach (used_mark[i]) begin
      used_mark[i] = 0; run_len[i] = 0; ref_cnt[i] = 0;
    end
    quiet_phase = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before init nothing is managed
    pending_items.push_back(make_item(OP_ALLOC, 1, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0));
    pending_items.push_back(make_item(OP_FREE, 0, 1023));
    wait_idle();

    // directed: small table with reserved and table pages
    write_reg(CFG_TOTAL, 11'd40);
    write_reg(CFG_RESERVED, 11'd3);
    write_reg(CFG_TABLE, 11'd2);
    pending_items.push_back(make_item(OP_INIT, 0, 0));
    pending_items.push_back(make_item(OP_ALLOC, 0, 0));
    pending_items.push_back(make_item(OP_ALLOC, 4, 0));
    pending_items.push_back(make_item(OP_ALLOC, 2047, 0));
    pending_items.push_back(make_item(OP_ALLOC, 35, 0));
    pending_items.push_back(make_item(OP_READ, 0, 5));
    pending_items.push_back(make_item(OP_INC, 0, 5));
    pending_items.push_back(make_item(OP_DEC, 0, 6));
    pending_items.push_back(make_item(OP_DEC, 0, 6));
    pending_items.push_back(make_item(OP_FREE, 0, 5));
    pending_items.push_back(make_item(OP_FREE, 0, 0));
    pending_items.push_back(make_item(OP_READ, 0, 39));
    pending_items.push_back(make_item(OP_READ, 0, 40));
    pending_items.push_back(make_item(OP_FREE, 0, 1023));
    pending_items.push_back(make_item(opcode_t'(3'd6), 0, 7));
    pending_items.push_back(make_item(opcode_t'(3'd7), 2047, 1023));
    // step one page's count up with repeated increments
    for (int k = 0; k < 4; k++) pending_items.push_back(make_item(OP_INC, 0, 10));
    wait_idle();

    // phases over several settings, the extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TOTAL, 11'd64); write_reg(CFG_RESERVED, 11'd0);
                 write_reg(CFG_TABLE, 11'd0); end
        1: begin write_reg(CFG_TOTAL, 11'd2047); write_reg(CFG_RESERVED, 11'd1000);
                 write_reg(CFG_TABLE, 11'd2047); end
        2: begin write_reg(CFG_TOTAL, 11'd1); write_reg(CFG_RESERVED, 11'd2047);
                 write_reg(CFG_TABLE, 11'd0); end
        3: begin write_reg(CFG_TOTAL, 11'd1024); write_reg(CFG_RESERVED, 11'd1000);
                 write_reg(CFG_TABLE, 11'd4); end
        default: begin
          write_reg(CFG_TOTAL, 11'($urandom_range(20, 100)));
          write_reg(CFG_RESERVED, 11'($urandom_range(0, 5)));
          write_reg(CFG_TABLE, 11'($urandom_range(0, 5)));
          quiet_phase = 1;
        end
      endcase
      pending_items.push_back(make_item(OP_INIT, $urandom, $urandom));
      queue_random(ph == 0 ? 250 : (ph == 4 ? 150 : 50),
        (total_reg < 1024) ? ((total_reg == 0) ? 0 : total_reg - 1) : 1023);
      wait_idle();
    end

    if (failed) $display("simulation failed");
    else $display("simulation ok");
    $finish;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

endmodule
